// ===== hdl/prt_pkg.sv =====
// prt_pkg: shared constants and types for the pending request tracker
// table geometry, operation modes, status and event codes, entry layout
// no dependencies
package prt_pkg;

    // table geometry
    localparam int TABLE_DEPTH = 16;
    localparam int TAG_WIDTH   = 8;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    // port field widths
    localparam int MODE_W   = 2;
    localparam int ID_W     = 32;
    localparam int TIME_W   = 32;
    localparam int TAGP_W   = 8;
    localparam int STATUS_W = 3;
    localparam int EVENT_W  = 2;
    localparam int COUNT_W  = 5;

    // operation modes
    localparam logic [MODE_W-1:0] MODE_REGISTER = 2'd0;
    localparam logic [MODE_W-1:0] MODE_CANCEL   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_RESOLVE  = 2'd2;
    localparam logic [MODE_W-1:0] MODE_TICK     = 2'd3;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_INVALID   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_IN_USE    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd4;

    // event codes
    localparam logic [EVENT_W-1:0] EV_NONE     = 2'd0;
    localparam logic [EVENT_W-1:0] EV_RESPONSE = 2'd1;
    localparam logic [EVENT_W-1:0] EV_TIMEOUT  = 2'd2;

    // one table entry as held in the entry memory
    typedef struct packed {
        logic [ID_W-1:0]      corr;
        logic [TIME_W-1:0]    deadline;
        logic [TAG_WIDTH-1:0] tag;
    } entry_t;

endpackage

// ===== hdl/pending_request_tracker.sv =====
// pending_request_tracker: table of outstanding requests with timeout expiry
// holds the entry memory, per-entry valid flops and the scan sequencer
// depends on prt_pkg
//
// A transaction is taken when start is high and busy is low; busy then stays
// high up to the cycle in which the last result of that transaction is shown,
// and is already low in that cycle. Results come
// out on done, one per cycle, and must be captured in that cycle since the
// block cannot be held off. Register, cancel and resolve give one result;
// a tick gives one timeout result per expired entry in slot order and carries
// the expiry count on its final result. A transaction with an invalid argument
// skips the scan and goes from start straight to its result; every other one
// reads the entry memory once per slot through its single read port before
// giving its final result. Tick timeout results appear during the scan,
// trailing each found entry by one expired entry. The valid flags are cleared
// by reset, so no clearing pass is needed.
module pending_request_tracker
    import prt_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [MODE_W-1:0]   mode,
    input  logic [ID_W-1:0]     correlation_id,
    input  logic [TIME_W-1:0]   deadline_ms,
    input  logic [TIME_W-1:0]   now_ms,
    input  logic [TAGP_W-1:0]   requester_tag,
    input  logic                handler_present,
    input  logic                is_response,
    output logic                done,
    output logic [STATUS_W-1:0] status,
    output logic [EVENT_W-1:0]  event_res,
    output logic [TAGP_W-1:0]   tag_out,
    output logic [ID_W-1:0]     correlation_out,
    output logic [COUNT_W-1:0]  expired_count,
    output logic                last
);

    // sequencer states
    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SCAN   = 2'd1;
    localparam logic [1:0] S_FINISH = 2'd2;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

    // entry memory and its read data
    entry_t mem [TABLE_DEPTH];
    entry_t rd_data_reg;

    logic [1:0]             state_reg;
    logic [TABLE_DEPTH-1:0] valid_reg;

    // latched transaction
    logic [MODE_W-1:0]    mode_reg;
    logic [ID_W-1:0]      id_reg;
    logic [TIME_W-1:0]    deadline_reg;
    logic [TIME_W-1:0]    now_reg;
    logic [TAG_WIDTH-1:0] req_tag_reg;
    logic                 fail_reg;

    // scan pipeline
    logic [CNT_W-1:0] rd_cnt_reg;
    logic             rd_vld_reg;
    logic [IDX_W-1:0] rd_idx_reg;

    // scan findings
    logic                 found_reg;
    logic [IDX_W-1:0]     hit_idx_reg;
    logic [TAG_WIDTH-1:0] held_tag_reg;
    logic [ID_W-1:0]      held_corr_reg;
    logic                 dup_reg;
    logic                 free_found_reg;
    logic [IDX_W-1:0]     free_idx_reg;
    logic [COUNT_W-1:0]   count_reg;

    // result registers
    logic                done_reg;
    logic [STATUS_W-1:0] status_reg;
    logic [EVENT_W-1:0]  event_reg;
    logic [TAGP_W-1:0]   tag_out_reg;
    logic [ID_W-1:0]     corr_out_reg;
    logic [COUNT_W-1:0]  count_out_reg;
    logic                last_reg;

    logic             accept;
    logic             start_fail;
    logic             issue;
    logic [IDX_W-1:0] rd_addr;
    logic             ent_valid;
    logic             ent_hit;
    logic             ent_free;
    logic             ent_expire;
    logic [TIME_W-1:0] age;
    logic             mem_we;
    entry_t           mem_wdata;

    assign busy   = (state_reg != S_IDLE);
    assign accept = start && !busy;

    // argument checks done at accept time
    assign start_fail = ((mode == MODE_REGISTER) && ((correlation_id == '0) || !handler_present))
                     || ((mode == MODE_CANCEL) && (correlation_id == '0))
                     || ((mode == MODE_RESOLVE) && ((correlation_id == '0) || !is_response));

    // read issue, one slot per cycle
    assign issue   = (state_reg == S_SCAN) && (rd_cnt_reg < CNT_W'(TABLE_DEPTH));
    assign rd_addr = rd_cnt_reg[IDX_W-1:0];

    // entry evaluation on returned read data
    assign ent_valid  = valid_reg[rd_idx_reg];
    assign age        = now_reg - rd_data_reg.deadline;
    assign ent_hit    = rd_vld_reg && ent_valid && (rd_data_reg.corr == id_reg);
    assign ent_free   = rd_vld_reg && !ent_valid;
    assign ent_expire = rd_vld_reg && ent_valid && !age[TIME_W-1];

    // new entry write at the end of a successful register
    assign mem_we = (state_reg == S_FINISH) && (mode_reg == MODE_REGISTER)
                 && !fail_reg && !dup_reg && free_found_reg;
    assign mem_wdata = '{corr: id_reg, deadline: deadline_reg, tag: req_tag_reg};

    // entry memory, synchronous read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[free_idx_reg] <= mem_wdata;
        end
        if (issue)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // sequencer, valid flags and results
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            valid_reg      <= '0;
            rd_cnt_reg     <= '0;
            rd_vld_reg     <= 1'b0;
            rd_idx_reg     <= '0;
            found_reg      <= 1'b0;
            dup_reg        <= 1'b0;
            free_found_reg <= 1'b0;
            count_reg      <= '0;
            done_reg       <= 1'b0;
            last_reg       <= 1'b0;
        end
        else
        begin
            done_reg   <= 1'b0;
            rd_vld_reg <= issue;
            rd_idx_reg <= rd_addr;
            if (issue)
            begin
                rd_cnt_reg <= rd_cnt_reg + CNT_W'(1);
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        state_reg      <= start_fail ? S_FINISH : S_SCAN;
                        rd_cnt_reg     <= '0;
                        found_reg      <= 1'b0;
                        dup_reg        <= 1'b0;
                        free_found_reg <= 1'b0;
                        count_reg      <= '0;
                    end
                end

                S_SCAN:
                begin
                    if ((mode_reg == MODE_CANCEL) || (mode_reg == MODE_RESOLVE))
                    begin
                        if (ent_hit && !found_reg)
                        begin
                            found_reg <= 1'b1;
                        end
                    end
                    else if (mode_reg == MODE_REGISTER)
                    begin
                        if (ent_hit)
                        begin
                            dup_reg <= 1'b1;
                        end
                        if (ent_free && !free_found_reg)
                        begin
                            free_found_reg <= 1'b1;
                        end
                    end
                    else
                    begin
                        // tick: free the entry, flush the previously held one
                        if (ent_expire)
                        begin
                            valid_reg[rd_idx_reg] <= 1'b0;
                            found_reg             <= 1'b1;
                            count_reg             <= count_reg + COUNT_W'(1);
                            if (found_reg)
                            begin
                                done_reg <= 1'b1;
                                last_reg <= 1'b0;
                            end
                        end
                    end
                    if (rd_vld_reg && (rd_idx_reg == LAST_IDX))
                    begin
                        state_reg <= S_FINISH;
                    end
                end

                S_FINISH:
                begin
                    state_reg <= S_IDLE;
                    done_reg  <= 1'b1;
                    last_reg  <= 1'b1;
                    if (mem_we)
                    begin
                        valid_reg[free_idx_reg] <= 1'b1;
                    end
                    if (((mode_reg == MODE_CANCEL) || (mode_reg == MODE_RESOLVE))
                        && !fail_reg && found_reg)
                    begin
                        valid_reg[hit_idx_reg] <= 1'b0;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // transaction latch, scan payload and result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mode_reg     <= mode;
            id_reg       <= correlation_id;
            deadline_reg <= deadline_ms;
            now_reg      <= now_ms;
            req_tag_reg  <= TAG_WIDTH'(requester_tag);
            fail_reg     <= start_fail;
        end

        // capture first free slot and matched or expired entry
        if (state_reg == S_SCAN)
        begin
            if ((mode_reg == MODE_REGISTER) && ent_free && !free_found_reg)
            begin
                free_idx_reg <= rd_idx_reg;
            end
            if ((((mode_reg == MODE_CANCEL) || (mode_reg == MODE_RESOLVE))
                 && ent_hit && !found_reg)
                || ((mode_reg == MODE_TICK) && ent_expire))
            begin
                hit_idx_reg   <= rd_idx_reg;
                held_tag_reg  <= rd_data_reg.tag;
                held_corr_reg <= rd_data_reg.corr;
            end
            // timeout result for the held entry
            if ((mode_reg == MODE_TICK) && ent_expire && found_reg)
            begin
                status_reg    <= ST_OK;
                event_reg     <= EV_TIMEOUT;
                tag_out_reg   <= TAGP_W'(held_tag_reg);
                corr_out_reg  <= held_corr_reg;
                count_out_reg <= '0;
            end
        end

        // final result of the transaction
        if (state_reg == S_FINISH)
        begin
            status_reg    <= ST_OK;
            event_reg     <= EV_NONE;
            tag_out_reg   <= '0;
            corr_out_reg  <= '0;
            count_out_reg <= '0;
            priority if (fail_reg)
            begin
                status_reg <= ST_INVALID;
            end
            else if (mode_reg == MODE_REGISTER)
            begin
                if (dup_reg)
                begin
                    status_reg <= ST_IN_USE;
                end
                else if (!free_found_reg)
                begin
                    status_reg <= ST_FULL;
                end
            end
            else if (mode_reg == MODE_TICK)
            begin
                if (found_reg)
                begin
                    event_reg     <= EV_TIMEOUT;
                    tag_out_reg   <= TAGP_W'(held_tag_reg);
                    corr_out_reg  <= held_corr_reg;
                    count_out_reg <= count_reg;
                end
            end
            else if (!found_reg)
            begin
                status_reg <= ST_NOT_FOUND;
            end
            else if (mode_reg == MODE_RESOLVE)
            begin
                event_reg    <= EV_RESPONSE;
                tag_out_reg  <= TAGP_W'(held_tag_reg);
                corr_out_reg <= held_corr_reg;
            end
        end
    end

    // result ports
    assign done            = done_reg;
    assign status          = status_reg;
    assign event_res       = event_reg;
    assign tag_out         = tag_out_reg;
    assign correlation_out = corr_out_reg;
    assign expired_count   = count_out_reg;
    assign last            = last_reg;

    // accepted transaction always raises busy
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy)
        else $error("busy not raised after accepted transaction");

    // final result is shown with the block already released
    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (done && last) |-> !busy)
        else $error("block still busy during final result");

    // only tick timeouts produce non-final results
    a_nonlast_timeout: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !last) |-> (event_res == EV_TIMEOUT && expired_count == '0))
        else $error("non-final result that is not a timeout");

    // events carry ok status
    a_event_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (done && event_res != EV_NONE) |-> (status == ST_OK))
        else $error("event with failing status");

    // no result unless a transaction was in progress
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result without a transaction in progress");

endmodule
